### sv/psev_pkg.sv
package psev_pkg;

    // Operator character codes
    localparam logic [7:0] OP_ADD = 8'h2B;
    localparam logic [7:0] OP_SUB = 8'h2D;
    localparam logic [7:0] OP_MUL = 8'h2A;
    localparam logic [7:0] OP_DIV = 8'h2F;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK,
        ST_UNDER,
        ST_FULL,
        ST_DIVZ,
        ST_BADOP,
        ST_FINAL
    } status_t;

    // Jump conditions: jump to target when true, else step on
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_IS_OP,
        C_FULL,
        C_BAD_OP,
        C_SP_LT2,
        C_OP_DIV,
        C_OP_MUL,
        C_B_ZERO,
        C_CNT_MORE,
        C_OUT_BUSY
    } cond_t;

    // Stack read address select
    typedef enum logic {
        ADDR_SP1,
        ADDR_SP2
    } addr_t;

    // Datapath actions
    typedef enum logic [4:0] {
        A_NONE,
        A_ACCEPT,
        A_PUSH,
        A_SET_FULL,
        A_SET_UNDER,
        A_LOAD_B,
        A_LOAD_A,
        A_ADDSUB,
        A_MUL,
        A_MUL_SAT,
        A_DIV_INIT,
        A_DIV_STEP,
        A_DIV_FIN,
        A_DIV_ZERO,
        A_WRITE,
        A_TOP,
        A_BADOP,
        A_EMIT
    } act_t;

    localparam int PC_W = 5;

    typedef struct packed {
        cond_t            cond;
        logic [PC_W-1:0]  target;
        addr_t            addr;
        act_t             act;
    } cw_t;

    // Program step addresses
    localparam logic [PC_W-1:0] S_WAIT  = 5'd0;
    localparam logic [PC_W-1:0] S_KIND  = 5'd1;
    localparam logic [PC_W-1:0] S_PCHK  = 5'd2;
    localparam logic [PC_W-1:0] S_PUSH  = 5'd3;
    localparam logic [PC_W-1:0] S_FULL  = 5'd4;
    localparam logic [PC_W-1:0] S_OPCHK = 5'd5;
    localparam logic [PC_W-1:0] S_CNT   = 5'd6;
    localparam logic [PC_W-1:0] S_RDB   = 5'd7;
    localparam logic [PC_W-1:0] S_RDA   = 5'd8;
    localparam logic [PC_W-1:0] S_SEL   = 5'd9;
    localparam logic [PC_W-1:0] S_MSEL  = 5'd10;
    localparam logic [PC_W-1:0] S_ADD   = 5'd11;
    localparam logic [PC_W-1:0] S_MUL   = 5'd12;
    localparam logic [PC_W-1:0] S_MSAT  = 5'd13;
    localparam logic [PC_W-1:0] S_DCHK  = 5'd14;
    localparam logic [PC_W-1:0] S_DINIT = 5'd15;
    localparam logic [PC_W-1:0] S_DLOOP = 5'd16;
    localparam logic [PC_W-1:0] S_DFIN  = 5'd17;
    localparam logic [PC_W-1:0] S_DZERO = 5'd18;
    localparam logic [PC_W-1:0] S_WRITE = 5'd19;
    localparam logic [PC_W-1:0] S_UNDER = 5'd20;
    localparam logic [PC_W-1:0] S_TOP   = 5'd21;
    localparam logic [PC_W-1:0] S_BAD   = 5'd22;
    localparam logic [PC_W-1:0] S_EMIT  = 5'd23;
    localparam logic [PC_W-1:0] S_BACK  = 5'd24;

    // True for one of the four operator characters
    function automatic logic op_valid(input logic [7:0] c);
        return (c == OP_ADD) || (c == OP_SUB) || (c == OP_MUL) || (c == OP_DIV);
    endfunction

    // Control store: one word per program step
    function automatic cw_t ucode_rom(input logic [PC_W-1:0] pc);
        cw_t w;
        w = '{cond: C_ALWAYS, target: S_WAIT, addr: ADDR_SP1, act: A_NONE};
        case (pc)
            S_WAIT:  w = '{cond: C_NO_REQ,   target: S_WAIT,  addr: ADDR_SP1, act: A_ACCEPT};
            S_KIND:  w = '{cond: C_IS_OP,    target: S_OPCHK, addr: ADDR_SP1, act: A_NONE};
            S_PCHK:  w = '{cond: C_FULL,     target: S_FULL,  addr: ADDR_SP1, act: A_NONE};
            S_PUSH:  w = '{cond: C_ALWAYS,   target: S_EMIT,  addr: ADDR_SP1, act: A_PUSH};
            S_FULL:  w = '{cond: C_ALWAYS,   target: S_TOP,   addr: ADDR_SP1, act: A_SET_FULL};
            S_OPCHK: w = '{cond: C_BAD_OP,   target: S_BAD,   addr: ADDR_SP1, act: A_NONE};
            S_CNT:   w = '{cond: C_SP_LT2,   target: S_UNDER, addr: ADDR_SP1, act: A_NONE};
            S_RDB:   w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_NONE};
            S_RDA:   w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP2, act: A_LOAD_B};
            S_SEL:   w = '{cond: C_OP_DIV,   target: S_DCHK,  addr: ADDR_SP1, act: A_LOAD_A};
            S_MSEL:  w = '{cond: C_OP_MUL,   target: S_MUL,   addr: ADDR_SP1, act: A_NONE};
            S_ADD:   w = '{cond: C_ALWAYS,   target: S_WRITE, addr: ADDR_SP1, act: A_ADDSUB};
            S_MUL:   w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_MUL};
            S_MSAT:  w = '{cond: C_ALWAYS,   target: S_WRITE, addr: ADDR_SP1, act: A_MUL_SAT};
            S_DCHK:  w = '{cond: C_B_ZERO,   target: S_DZERO, addr: ADDR_SP1, act: A_NONE};
            S_DINIT: w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_DIV_INIT};
            S_DLOOP: w = '{cond: C_CNT_MORE, target: S_DLOOP, addr: ADDR_SP1, act: A_DIV_STEP};
            S_DFIN:  w = '{cond: C_ALWAYS,   target: S_WRITE, addr: ADDR_SP1, act: A_DIV_FIN};
            S_DZERO: w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_DIV_ZERO};
            S_WRITE: w = '{cond: C_ALWAYS,   target: S_EMIT,  addr: ADDR_SP1, act: A_WRITE};
            S_UNDER: w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_SET_UNDER};
            S_TOP:   w = '{cond: C_ALWAYS,   target: S_EMIT,  addr: ADDR_SP1, act: A_TOP};
            S_BAD:   w = '{cond: C_NEVER,    target: S_WAIT,  addr: ADDR_SP1, act: A_BADOP};
            S_EMIT:  w = '{cond: C_OUT_BUSY, target: S_EMIT,  addr: ADDR_SP1, act: A_EMIT};
            S_BACK:  w = '{cond: C_ALWAYS,   target: S_WAIT,  addr: ADDR_SP1, act: A_NONE};
            default: w = '{cond: C_ALWAYS,   target: S_WAIT,  addr: ADDR_SP1, act: A_NONE};
        endcase
        return w;
    endfunction

endpackage

### sv/postfix_stack_evaluator_core.sv
// One item at a time: the next request is taken only after the result is valid. The
// bit-serial restoring divider (32 + FRAC_BITS steps) sets the worst case; a new request is
// taken while an earlier result still waits on the output. Reset clears the step counter,
// the stack pointer and the output valid; stack entries are not cleared and hold their old
// contents until pushed again.
module postfix_stack_evaluator_core #(
    parameter int STACK_DEPTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // number [31:0], op_char [39:32]
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // top_value [31:0], stack_depth [37:32], status [40:38]
    output logic        m_tlast
);

    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int QW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
    localparam logic [31:0]        MAX32  = 32'h7FFF_FFFF;
    localparam logic [31:0]        MIN32  = 32'h8000_0000;

    // Sequencer
    logic [psev_pkg::PC_W-1:0] pc_reg, pc_next;
    psev_pkg::cw_t             cw;
    logic                      jump;

    // Token and operands
    logic                  cmd_reg;
    logic signed [31:0]    num_reg;
    logic [7:0]            op_reg;
    logic                  last_reg;
    logic [SP_W-1:0]       sp_reg;
    logic signed [31:0]    a_reg, b_reg;
    logic [31:0]           res_reg;
    psev_pkg::status_t     status_reg;
    logic signed [63:0]    prod_reg;

    // Divider
    logic [QW-1:0]         dvd_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           dsr_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Stack memory
    logic [31:0]           stack_mem [STACK_DEPTH];
    logic [31:0]           rd_reg;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [31:0]           wr_data;
    logic                  mem_we;
    logic [SP_W-1:0]       sp_m1, sp_m2;

    // Output register
    logic                  m_tvalid_reg;
    logic [31:0]           top_out_reg;
    logic [5:0]            depth_out_reg;
    psev_pkg::status_t     status_out_reg;
    logic                  last_out_reg;

    logic                  out_free, emit_fire;
    psev_pkg::status_t     status_fin;

    // Arithmetic
    logic signed [32:0]    sum_ext;
    logic [31:0]           addsub_sat;
    logic signed [63:0]    mul_sh;
    logic [31:0]           mul_sat;
    logic [31:0]           a_abs, b_abs;
    logic [32:0]           rem_shift, rem_diff;
    logic                  qbit;
    logic [63:0]           q64;
    logic [31:0]           div_sat;

    // Fetch control word and pick next step
    assign cw = psev_pkg::ucode_rom(pc_reg);

    always_comb begin
        case (cw.cond)
            psev_pkg::C_NEVER:    jump = 1'b0;
            psev_pkg::C_ALWAYS:   jump = 1'b1;
            psev_pkg::C_NO_REQ:   jump = !s_tvalid;
            psev_pkg::C_IS_OP:    jump = cmd_reg;
            psev_pkg::C_FULL:     jump = (sp_reg >= SP_W'(STACK_DEPTH));
            psev_pkg::C_BAD_OP:   jump = !psev_pkg::op_valid(op_reg);
            psev_pkg::C_SP_LT2:   jump = (sp_reg < SP_W'(2));
            psev_pkg::C_OP_DIV:   jump = (op_reg == psev_pkg::OP_DIV);
            psev_pkg::C_OP_MUL:   jump = (op_reg == psev_pkg::OP_MUL);
            psev_pkg::C_B_ZERO:   jump = (b_reg == 32'sd0);
            psev_pkg::C_CNT_MORE: jump = (cnt_reg != CNT_W'(1));
            psev_pkg::C_OUT_BUSY: jump = !out_free;
            default:              jump = 1'b0;
        endcase
        pc_next = jump ? cw.target : pc_reg + psev_pkg::PC_W'(1);
    end

    assign s_tready  = aresetn && (cw.act == psev_pkg::A_ACCEPT);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = (cw.act == psev_pkg::A_EMIT) && out_free;

    // Flag a bad final form where the token itself raised no error
    assign status_fin = (last_reg && status_reg == psev_pkg::ST_OK && sp_reg != SP_W'(1))
                        ? psev_pkg::ST_FINAL : status_reg;

    // Saturating add and subtract
    always_comb begin
        if (op_reg == psev_pkg::OP_SUB) begin
            sum_ext = {a_reg[31], a_reg} - {b_reg[31], b_reg};
        end else begin
            sum_ext = {a_reg[31], a_reg} + {b_reg[31], b_reg};
        end
        if (sum_ext[32] != sum_ext[31]) begin
            addsub_sat = sum_ext[32] ? MIN32 : MAX32;
        end else begin
            addsub_sat = sum_ext[31:0];
        end
    end

    // Scale and saturate the registered product (shift rounds toward minus infinity)
    always_comb begin
        mul_sh = prod_reg >>> FRAC_BITS;
        if (mul_sh > SAT_HI) begin
            mul_sat = MAX32;
        end else if (mul_sh < SAT_LO) begin
            mul_sat = MIN32;
        end else begin
            mul_sat = mul_sh[31:0];
        end
    end

    // Magnitudes, one restoring step and the signed, saturated quotient
    always_comb begin
        a_abs     = a_reg[31] ? 32'(-a_reg) : a_reg;
        b_abs     = b_reg[31] ? 32'(-b_reg) : b_reg;
        rem_shift = {rem_reg, dvd_reg[QW-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        qbit      = !rem_diff[32];
        q64       = 64'(dvd_reg);
        if (neg_reg) begin
            div_sat = (q64 > 64'h8000_0000) ? MIN32 : 32'(-q64);
        end else begin
            div_sat = (q64 > 64'h7FFF_FFFF) ? MAX32 : q64[31:0];
        end
    end

    // Stack addresses and write port
    always_comb begin
        sp_m1   = sp_reg - SP_W'(1);
        sp_m2   = sp_reg - SP_W'(2);
        rd_addr = (cw.addr == psev_pkg::ADDR_SP2) ? sp_m2[AW-1:0] : sp_m1[AW-1:0];
        mem_we  = (cw.act == psev_pkg::A_PUSH) || (cw.act == psev_pkg::A_WRITE);
        wr_addr = (cw.act == psev_pkg::A_PUSH) ? sp_reg[AW-1:0] : sp_m2[AW-1:0];
        wr_data = (cw.act == psev_pkg::A_PUSH) ? num_reg : res_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= wr_data;
        end
        rd_reg <= stack_mem[rd_addr];
    end

    // Hold step counter, stack pointer and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= psev_pkg::S_WAIT;
            sp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end
            case (cw.act)
                psev_pkg::A_PUSH:  sp_reg <= sp_reg + SP_W'(1);
                psev_pkg::A_WRITE: sp_reg <= sp_m1;
                psev_pkg::A_BADOP: sp_reg <= '0;
                psev_pkg::A_EMIT: begin
                    if (emit_fire && last_reg) begin
                        sp_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath actions driven by the control word
    always_ff @(posedge aclk) begin
        case (cw.act)
            psev_pkg::A_ACCEPT: begin
                if (s_tvalid) begin
                    cmd_reg    <= s_tuser;
                    num_reg    <= s_tdata[31:0];
                    op_reg     <= s_tdata[39:32];
                    last_reg   <= s_tlast;
                    status_reg <= psev_pkg::ST_OK;
                end
            end
            psev_pkg::A_PUSH:      res_reg <= num_reg;
            psev_pkg::A_SET_FULL:  status_reg <= psev_pkg::ST_FULL;
            psev_pkg::A_SET_UNDER: status_reg <= psev_pkg::ST_UNDER;
            psev_pkg::A_LOAD_B:    b_reg <= rd_reg;
            psev_pkg::A_LOAD_A:    a_reg <= rd_reg;
            psev_pkg::A_ADDSUB:    res_reg <= addsub_sat;
            psev_pkg::A_MUL:       prod_reg <= a_reg * b_reg;
            psev_pkg::A_MUL_SAT:   res_reg <= mul_sat;
            psev_pkg::A_DIV_INIT: begin
                dvd_reg <= QW'(a_abs) << FRAC_BITS;
                rem_reg <= '0;
                dsr_reg <= b_abs;
                neg_reg <= a_reg[31] ^ b_reg[31];
                cnt_reg <= CNT_W'(QW);
            end
            psev_pkg::A_DIV_STEP: begin
                rem_reg <= qbit ? rem_diff[31:0] : rem_shift[31:0];
                dvd_reg <= {dvd_reg[QW-2:0], qbit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            psev_pkg::A_DIV_FIN: res_reg <= div_sat;
            psev_pkg::A_DIV_ZERO: begin
                res_reg    <= '0;
                status_reg <= psev_pkg::ST_DIVZ;
            end
            psev_pkg::A_TOP:       res_reg <= (sp_reg != '0) ? rd_reg : 32'd0;
            psev_pkg::A_BADOP: begin
                res_reg    <= '0;
                status_reg <= psev_pkg::ST_BADOP;
            end
            psev_pkg::A_EMIT: begin
                if (emit_fire) begin
                    top_out_reg    <= res_reg;
                    depth_out_reg  <= 6'(sp_reg);
                    status_out_reg <= status_fin;
                    last_out_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, status_out_reg, depth_out_reg, top_out_reg};
    assign m_tlast  = last_out_reg;

    // Stack pointer never passes the stack depth
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // Closing a run empties the stack
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && last_reg) |=> (sp_reg == '0))
        else $error("stack not emptied after last token");

    // A dropped push is reported only on a full stack
    a_full_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && status_reg == psev_pkg::ST_FULL) |-> (sp_reg == SP_W'(STACK_DEPTH)))
        else $error("full reported below depth");

    // Underflow is reported only with fewer than two entries
    a_under_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && status_reg == psev_pkg::ST_UNDER) |-> (sp_reg < SP_W'(2)))
        else $error("underflow reported with two or more entries");

    // Divider loop never runs with an exhausted count
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.act == psev_pkg::A_DIV_STEP) |-> (cnt_reg != '0))
        else $error("divider step with zero count");

endmodule
